// ===== sv/wcr_pkg.sv =====
// Shared constants, field widths and codes for the waveform column rasterizer.
// Depends on nothing; imported by the core and the testbench.
package wcr_pkg;

   localparam int KIND_W         = 2;
   localparam int COL_W          = 12;
   localparam int AMP_W          = 15;
   localparam int ROW_W          = 8;
   localparam int BYTE_W         = 8;
   localparam int PIX_W          = 8;
   localparam int IMAGE_WIDTH_W  = 11;
   localparam int IMAGE_HEIGHT_W = 9;
   localparam int COLOR_W        = 2;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 11;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 256;

   localparam int ROUND_CONST    = 16384;
   localparam int SCALE_SHIFT    = 15;

   localparam logic [KIND_W-1:0] KIND_STEREO = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MONO   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

   localparam logic STATUS_DONE    = 1'b0;
   localparam logic STATUS_IGNORED = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEFT_COLOR   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RIGHT_COLOR  = 2'd3;

   localparam logic [IMAGE_WIDTH_W-1:0]  IMAGE_WIDTH_RST  = 11'd1024;
   localparam logic [IMAGE_HEIGHT_W-1:0] IMAGE_HEIGHT_RST = 9'd256;
   localparam logic [COLOR_W-1:0]        LEFT_COLOR_RST   = 2'd1;
   localparam logic [COLOR_W-1:0]        RIGHT_COLOR_RST  = 2'd2;

   function automatic int max_of(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

endpackage

// ===== sv/wcr_frame_ram.sv =====
// Frame store: one write port, one read port with registered read data.
// Depends on nothing; instantiated by the core.
module wcr_frame_ram #(
   parameter int DEPTH = 65536,
   parameter int AW    = 16,
   parameter int DW    = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/waveform_column_rasterizer_core.sv =====
// Top level of the waveform column rasterizer: sequencer, shared multiplier
// and read-modify-write walk over the frame store.
// Depends on wcr_pkg and wcr_frame_ram.
//
// Usage:
//   req_* carries one transaction: a stereo draw, a mono draw or a byte read.
//   rsp_* returns exactly one transaction for each request: status and pixel_byte.
//   csr_* writes image_width, image_height, left_color, right_color; write only
//   while no request is outstanding.
// Sequence:
//   A draw passes decode and the shared multiplier (two scale products and one
//   row-base product), then walks the covered rows, reading one byte and writing
//   the previous one back each cycle, and closes the walk.
//   A read passes decode, the row-base product, the address and the data states;
//   an ignored request goes from decode straight to the response.
//   One request at a time: req_stall is high from acceptance until the
//   response transaction has been taken; the next request can go in the cycle after.
// Reset:
//   Registers return to their defaults and the store of ((MAX_WIDTH+3)/4)*MAX_HEIGHT
//   bytes (65536 by default) is swept to zero, one byte a cycle; req_stall stays
//   high meanwhile. Configuration writes are taken during the sweep.
// Stall:
//   While rsp_stall is high the response holds and no new request is taken.
module waveform_column_rasterizer_core #(
   parameter int MAX_WIDTH  = wcr_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = wcr_pkg::MAX_HEIGHT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [wcr_pkg::KIND_W-1:0]          req_kind,
   input  logic [wcr_pkg::COL_W-1:0]           req_column,
   input  logic [wcr_pkg::AMP_W-1:0]           req_left_amp,
   input  logic [wcr_pkg::AMP_W-1:0]           req_right_amp,
   input  logic [wcr_pkg::ROW_W-1:0]           req_read_row,
   input  logic [wcr_pkg::BYTE_W-1:0]          req_read_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_status,
   output logic [wcr_pkg::PIX_W-1:0]           rsp_pixel_byte,
   input  logic                                csr_write,
   input  logic [wcr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [wcr_pkg::CSR_DATA_W-1:0]      csr_data
);

   import wcr_pkg::*;

   localparam int ROW_BYTES_MAX = (MAX_WIDTH + 3) / 4;
   localparam int STORE_BYTES   = ROW_BYTES_MAX * MAX_HEIGHT;
   localparam int AW            = $clog2(STORE_BYTES);
   localparam int WW            = $clog2(MAX_WIDTH + 1);
   localparam int HW            = $clog2(MAX_HEIGHT + 1);
   localparam int LWW           = $clog2(ROW_BYTES_MAX + 1);
   localparam int CWW           = max_of(max_of(WW, IMAGE_WIDTH_W), COL_W);
   localparam int CHW           = max_of(max_of(HW, IMAGE_HEIGHT_W), ROW_W);
   localparam int CBW           = max_of(LWW, BYTE_W);
   localparam int MUL_A_W       = max_of(max_of(AMP_W, HW), ROW_W);
   localparam int MUL_B_W       = max_of(HW, LWW);
   localparam int PW            = MUL_A_W + MUL_B_W;

   localparam logic [3:0] S_CLEAR   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_DECODE  = 4'd2;
   localparam logic [3:0] S_MUL_L   = 4'd3;
   localparam logic [3:0] S_MUL_R   = 4'd4;
   localparam logic [3:0] S_SPAN    = 4'd5;
   localparam logic [3:0] S_BASE    = 4'd6;
   localparam logic [3:0] S_ADDR    = 4'd7;
   localparam logic [3:0] S_WALK    = 4'd8;
   localparam logic [3:0] S_RD_MUL  = 4'd9;
   localparam logic [3:0] S_RD_ADDR = 4'd10;
   localparam logic [3:0] S_RD_DATA = 4'd11;
   localparam logic [3:0] S_RESP    = 4'd12;

   logic [3:0]                state_ff, state_in;
   logic [AW-1:0]             clr_ff, clr_in;

   logic [IMAGE_WIDTH_W-1:0]  image_width_ff;
   logic [IMAGE_HEIGHT_W-1:0] image_height_ff;
   logic [COLOR_W-1:0]        left_color_ff;
   logic [COLOR_W-1:0]        right_color_ff;

   logic [KIND_W-1:0]         kind_ff;
   logic [COL_W-1:0]          col_ff;
   logic [AMP_W-1:0]          lamp_ff;
   logic [AMP_W-1:0]          ramp_ff;
   logic [ROW_W-1:0]          rrow_ff;
   logic [BYTE_W-1:0]         rbyte_ff;

   logic [HW-1:0]             h_ff, h_in;
   logic [HW-1:0]             center_ff, center_in;
   logic [LWW-1:0]            lw_ff, lw_in;
   logic [HW-1:0]             hl_ff, hl_in;
   logic [HW-1:0]             hr_ff, hr_in;
   logic [HW-1:0]             y0_ff, y0_in;
   logic [HW-1:0]             y1_ff, y1_in;
   logic [HW-1:0]             y_ff, y_in;
   logic [AW-1:0]             addr_ff, addr_in;
   logic [PW-1:0]             prod_ff, prod_in;

   logic                      wr_pend_ff, wr_pend_in;
   logic [AW-1:0]             wr_addr_ff, wr_addr_in;
   logic [PIX_W-1:0]          wr_bits_ff, wr_bits_in;

   logic                      status_ff, status_in;
   logic [PIX_W-1:0]          pix_ff, pix_in;

   logic [MUL_A_W-1:0]        mul_a;
   logic [MUL_B_W-1:0]        mul_b;
   logic [PW:0]               round_sum;
   logic [HW-1:0]             scaled;

   logic [CWW-1:0]            img_w_ext, max_w_ext, used_w, col_ext;
   logic [CWW:0]              lw_sum;
   logic [CHW-1:0]            img_h_ext, max_h_ext, used_h, rrow_ext;
   logic                      col_bad, read_bad;
   logic [HW:0]               top_sum;
   logic [COLOR_W-1:0]        cur_color;

   logic                      ram_we;
   logic [AW-1:0]             ram_waddr, ram_raddr;
   logic [PIX_W-1:0]          ram_wdata, ram_rdata;

   wcr_frame_ram #(
      .DEPTH (STORE_BYTES),
      .AW    (AW),
      .DW    (PIX_W)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // geometry in use
   always_comb begin
      img_w_ext = CWW'(image_width_ff);
      max_w_ext = CWW'(MAX_WIDTH);
      used_w    = (img_w_ext < max_w_ext) ? img_w_ext : max_w_ext;
      col_ext   = CWW'(col_ff);
      col_bad   = (col_ext >= used_w);
      lw_sum    = {1'b0, used_w} + (CWW + 1)'(3);
      lw_in     = LWW'(lw_sum >> 2);
      img_h_ext = CHW'(image_height_ff);
      max_h_ext = CHW'(MAX_HEIGHT);
      used_h    = (img_h_ext < max_h_ext) ? img_h_ext : max_h_ext;
      h_in      = HW'(used_h);
      center_in = h_in >> 1;
      rrow_ext  = CHW'(rrow_ff);
      read_bad  = (rrow_ext >= used_h) || (CBW'(rbyte_ff) >= CBW'(lw_in));
   end

   // shared multiplier and rounding scaler
   always_comb begin
      unique case (state_ff)
         S_MUL_L: begin
            mul_a = MUL_A_W'(lamp_ff);
            mul_b = MUL_B_W'(center_ff);
         end
         S_MUL_R: begin
            mul_a = (kind_ff == KIND_MONO) ? MUL_A_W'(lamp_ff) : MUL_A_W'(ramp_ff);
            mul_b = MUL_B_W'(center_ff);
         end
         S_BASE: begin
            mul_a = MUL_A_W'(y0_ff);
            mul_b = MUL_B_W'(lw_ff);
         end
         default: begin
            mul_a = MUL_A_W'(rrow_ff);
            mul_b = MUL_B_W'(lw_ff);
         end
      endcase
      prod_in   = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};
      round_sum = {1'b0, prod_ff} + (PW + 1)'(ROUND_CONST);
      scaled    = round_sum[SCALE_SHIFT +: HW];
   end

   always_comb begin
      top_sum   = {1'b0, center_ff} + {1'b0, hr_ff};
      cur_color = (kind_ff == KIND_STEREO && y_ff >= center_ff) ? right_color_ff
                                                                : left_color_ff;
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      hl_in      = hl_ff;
      hr_in      = hr_ff;
      y0_in      = y0_ff;
      y1_in      = y1_ff;
      y_in       = y_ff;
      addr_in    = addr_ff;
      wr_pend_in = 1'b0;
      wr_addr_in = addr_ff;
      wr_bits_in = PIX_W'(cur_color) << {col_ff[1:0], 1'b0};
      status_in  = status_ff;
      pix_in     = pix_ff;
      ram_raddr  = addr_ff;
      unique case (state_ff)
         S_CLEAR: begin
            clr_in = AW'(clr_ff + AW'(1));
            if (clr_ff == AW'(STORE_BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            status_in = STATUS_IGNORED;
            pix_in    = '0;
            state_in  = S_RESP;
            if (kind_ff == KIND_STEREO || kind_ff == KIND_MONO) begin
               if (!col_bad) begin
                  status_in = STATUS_DONE;
                  state_in  = S_MUL_L;
               end
            end else if (kind_ff == KIND_READ) begin
               if (!read_bad) begin
                  status_in = STATUS_DONE;
                  state_in  = S_RD_MUL;
               end
            end
         end
         S_MUL_L: begin
            state_in = S_MUL_R;
         end
         S_MUL_R: begin
            hl_in    = scaled;
            state_in = S_SPAN;
         end
         S_SPAN: begin
            hr_in    = scaled;
            y0_in    = (hl_ff > center_ff) ? '0 : HW'(center_ff - hl_ff);
            state_in = S_BASE;
         end
         S_BASE: begin
            y1_in    = (top_sum >= {1'b0, h_ff}) ? h_ff : top_sum[HW-1:0];
            state_in = S_ADDR;
         end
         S_ADDR: begin
            addr_in  = AW'(AW'(prod_ff) + AW'(col_ff >> 2));
            y_in     = y0_ff;
            state_in = S_WALK;
         end
         S_WALK: begin
            if (y_ff < y1_ff) begin
               wr_pend_in = 1'b1;
               addr_in    = AW'(addr_ff + AW'(lw_ff));
               y_in       = HW'(y_ff + HW'(1));
            end else begin
               state_in = S_RESP;
            end
         end
         S_RD_MUL: begin
            state_in = S_RD_ADDR;
         end
         S_RD_ADDR: begin
            ram_raddr = AW'(AW'(prod_ff) + AW'(rbyte_ff));
            state_in  = S_RD_DATA;
         end
         S_RD_DATA: begin
            pix_in   = ram_rdata;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (state_ff == S_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = '0;
      end else begin
         ram_we    = wr_pend_ff;
         ram_waddr = wr_addr_ff;
         ram_wdata = ram_rdata | wr_bits_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLEAR;
         clr_ff          <= '0;
         wr_pend_ff      <= 1'b0;
         image_width_ff  <= IMAGE_WIDTH_RST;
         image_height_ff <= IMAGE_HEIGHT_RST;
         left_color_ff   <= LEFT_COLOR_RST;
         right_color_ff  <= RIGHT_COLOR_RST;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         wr_pend_ff <= wr_pend_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_IMAGE_WIDTH:  image_width_ff  <= IMAGE_WIDTH_W'(csr_data);
               CSR_IMAGE_HEIGHT: image_height_ff <= IMAGE_HEIGHT_W'(csr_data);
               CSR_LEFT_COLOR:   left_color_ff   <= COLOR_W'(csr_data);
               CSR_RIGHT_COLOR:  right_color_ff  <= COLOR_W'(csr_data);
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         kind_ff  <= req_kind;
         col_ff   <= req_column;
         lamp_ff  <= req_left_amp;
         ramp_ff  <= req_right_amp;
         rrow_ff  <= req_read_row;
         rbyte_ff <= req_read_byte;
      end
      if (state_ff == S_DECODE) begin
         h_ff      <= h_in;
         center_ff <= center_in;
         lw_ff     <= lw_in;
      end
      prod_ff    <= prod_in;
      hl_ff      <= hl_in;
      hr_ff      <= hr_in;
      y0_ff      <= y0_in;
      y1_ff      <= y1_in;
      y_ff       <= y_in;
      addr_ff    <= addr_in;
      wr_addr_ff <= wr_addr_in;
      wr_bits_ff <= wr_bits_in;
      status_ff  <= status_in;
      pix_ff     <= pix_in;
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = (state_ff == S_RESP);
   assign rsp_status     = status_ff;
   assign rsp_pixel_byte = pix_ff;

endmodule

// ===== tb/waveform_column_rasterizer_core_tb.sv =====
// Self-checking testbench for waveform_column_rasterizer_core: a mirror of the
// packed frame store predicts every response; random idling on both channels.
// Depends on wcr_pkg and the core RTL only.
module waveform_column_rasterizer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wcr_pkg::*;

   localparam int unsigned STORE_BYTES   = ((MAX_WIDTH_DEF + 3) / 4) * MAX_HEIGHT_DEF;
   localparam int unsigned LIMIT_CYCLES  = 2_500_000;
   localparam int unsigned SETTLE_CYCLES = MAX_HEIGHT_DEF + 40;
   localparam int unsigned RECENT_DEPTH  = 8;

   localparam logic [KIND_W-1:0] KIND_UNUSED    = 2'd3;

   typedef struct packed {
      logic             status;
      logic [PIX_W-1:0] pixel_byte;
   } answer_type;

   class frame_mirror_type;
      bit   [PIX_W-1:0]          frame_bytes [STORE_BYTES];
      logic [IMAGE_WIDTH_W-1:0]  width_reg;
      logic [IMAGE_HEIGHT_W-1:0] height_reg;
      logic [COLOR_W-1:0]        left_color;
      logic [COLOR_W-1:0]        right_color;
      answer_type                awaited_answers [$];
      int unsigned               failures;

      function new();
         width_reg   = IMAGE_WIDTH_RST;
         height_reg  = IMAGE_HEIGHT_RST;
         left_color  = LEFT_COLOR_RST;
         right_color = RIGHT_COLOR_RST;
         failures    = 0;
      endfunction

      function int unsigned used_width();
         return (width_reg < MAX_WIDTH_DEF) ? width_reg : MAX_WIDTH_DEF;
      endfunction

      function int unsigned used_height();
         return (height_reg < MAX_HEIGHT_DEF) ? height_reg : MAX_HEIGHT_DEF;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_IMAGE_WIDTH:  width_reg   = data[IMAGE_WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: height_reg  = data[IMAGE_HEIGHT_W-1:0];
            CSR_LEFT_COLOR:   left_color  = data[COLOR_W-1:0];
            CSR_RIGHT_COLOR:  right_color = data[COLOR_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned scaled(logic [AMP_W-1:0] amp, int unsigned center);
         return (32'(amp) * center + ROUND_CONST) >> SCALE_SHIFT;
      endfunction

      function void paint(int unsigned col, int unsigned row_len, int unsigned y0,
                          int unsigned y1, logic [COLOR_W-1:0] color);
         logic [PIX_W-1:0] bits;
         int unsigned      idx;
         bits = PIX_W'(color) << (2 * (col & 3));
         for (int unsigned y = y0; y < y1; y++) begin
            idx = y * row_len + (col >> 2);
            if (idx < STORE_BYTES) frame_bytes[idx] |= bits;
         end
      endfunction

      function void take_request(logic [KIND_W-1:0] kind, logic [COL_W-1:0] column,
                                 logic [AMP_W-1:0] lamp, logic [AMP_W-1:0] ramp,
                                 logic [ROW_W-1:0] row, logic [BYTE_W-1:0] rbyte);
         int unsigned uw, uh, center, row_len, hl, hr, y0, y1, idx;
         answer_type  ans;
         uw      = used_width();
         uh      = used_height();
         center  = uh >> 1;
         row_len = (uw + 3) >> 2;
         ans.status     = STATUS_DONE;
         ans.pixel_byte = '0;
         case (kind)
            KIND_STEREO, KIND_MONO: begin
               if (column >= uw) begin
                  ans.status = STATUS_IGNORED;
               end else if (kind == KIND_STEREO) begin
                  hl = scaled(lamp, center);
                  hr = scaled(ramp, center);
                  y0 = (hl > center) ? 0 : center - hl;
                  y1 = (center + hr < uh) ? center + hr : uh;
                  paint(column, row_len, y0, (center < uh) ? center : uh, left_color);
                  paint(column, row_len, center, y1, right_color);
               end else begin
                  hl = scaled(lamp, center);
                  y0 = (hl > center) ? 0 : center - hl;
                  y1 = (center + hl < uh) ? center + hl : uh;
                  paint(column, row_len, y0, y1, left_color);
               end
            end
            KIND_READ: begin
               idx = row * row_len + rbyte;
               if (row >= uh || rbyte >= row_len || idx >= STORE_BYTES)
                  ans.status = STATUS_IGNORED;
               else
                  ans.pixel_byte = frame_bytes[idx];
            end
            default: ans.status = STATUS_IGNORED;
         endcase
         awaited_answers.push_back(ans);
      endfunction

      function void match_response(logic status, logic [PIX_W-1:0] pix);
         answer_type want;
         if (awaited_answers.size() == 0) begin
            $error("unexpected response transaction: status %0d, pixel_byte 0x%02h",
                   status, pix);
            failures++;
            return;
         end
         want = awaited_answers.pop_front();
         if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            failures++;
         end
         if (pix !== want.pixel_byte) begin
            $error("pixel_byte: expected 0x%02h, got 0x%02h", want.pixel_byte, pix);
            failures++;
         end
      endfunction
   endclass

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_stall;
   logic [KIND_W-1:0]      req_kind       = KIND_STEREO;
   logic [COL_W-1:0]       req_column     = '0;
   logic [AMP_W-1:0]       req_left_amp   = '0;
   logic [AMP_W-1:0]       req_right_amp  = '0;
   logic [ROW_W-1:0]       req_read_row   = '0;
   logic [BYTE_W-1:0]      req_read_byte  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall      = 1'b0;
   logic                   rsp_status;
   logic [PIX_W-1:0]       rsp_pixel_byte;
   logic                   csr_write      = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index      = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0]  csr_data       = '0;

   frame_mirror_type mirror = new();
   int unsigned idle_pct  = 0;
   int unsigned stall_pct = 0;
   int unsigned cycles_run;
   int unsigned painted_columns [$];

   waveform_column_rasterizer_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_column     (req_column),
      .req_left_amp   (req_left_amp),
      .req_right_amp  (req_right_amp),
      .req_read_row   (req_read_row),
      .req_read_byte  (req_read_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_pixel_byte (rsp_pixel_byte),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) mirror.match_response(rsp_status, rsp_pixel_byte);
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   initial begin
      cycles_run = 0;
      while (cycles_run < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("waveform_column_rasterizer_core regression: fail");
      $finish;
   end

   task automatic send_request(input logic [KIND_W-1:0] kind, input logic [COL_W-1:0] column,
                               input logic [AMP_W-1:0] lamp, input logic [AMP_W-1:0] ramp,
                               input logic [ROW_W-1:0] row, input logic [BYTE_W-1:0] rbyte);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_column    <= column;
      req_left_amp  <= lamp;
      req_right_amp <= ramp;
      req_read_row  <= row;
      req_read_byte <= rbyte;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      mirror.take_request(kind, column, lamp, ramp, row, rbyte);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (mirror.awaited_answers.size() != 0) @(posedge clock);
   endtask

   // leaves csr_write high; the caller drops it after the last write
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      mirror.set_register(index, data);
   endtask

   task automatic run_phase(input logic [IMAGE_WIDTH_W-1:0] width,
                            input logic [IMAGE_HEIGHT_W-1:0] height,
                            input logic [COLOR_W-1:0] lc, input logic [COLOR_W-1:0] rc,
                            input int unsigned idle, input int unsigned stall,
                            input int unsigned count);
      int unsigned       uw, uh, row_len, pick;
      logic [KIND_W-1:0] kind;
      logic [COL_W-1:0]  column;
      logic [AMP_W-1:0]  lamp, ramp;
      logic [ROW_W-1:0]  row;
      logic [BYTE_W-1:0] rbyte;
      drain();
      repeat (4) @(posedge clock);
      write_register(CSR_IMAGE_WIDTH, CSR_DATA_W'(width));
      write_register(CSR_IMAGE_HEIGHT, CSR_DATA_W'(height));
      write_register(CSR_LEFT_COLOR, CSR_DATA_W'(lc));
      write_register(CSR_RIGHT_COLOR, CSR_DATA_W'(rc));
      csr_write <= 1'b0;
      idle_pct  = idle;
      stall_pct = stall;
      painted_columns.delete();
      uw      = mirror.used_width();
      uh      = mirror.used_height();
      row_len = (uw + 3) >> 2;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 35)      kind = KIND_STEREO;
         else if (pick < 55) kind = KIND_MONO;
         else if (pick < 97) kind = KIND_READ;
         else                kind = KIND_UNUSED;

         pick = $urandom_range(99);
         if (uw == 0 || pick < 8) column = COL_W'($urandom_range(4095));
         else if (pick < 12)      column = COL_W'(uw);
         else                     column = COL_W'($urandom_range(uw - 1));

         pick = $urandom_range(99);
         lamp = (pick < 10) ? '0 : (pick < 20) ? '1 : AMP_W'($urandom_range(32767));
         pick = $urandom_range(99);
         ramp = (pick < 10) ? '0 : (pick < 20) ? '1 : AMP_W'($urandom_range(32767));

         pick = $urandom_range(99);
         row  = (uh > 0 && pick < 85) ? ROW_W'($urandom_range(uh - 1))
                                      : ROW_W'($urandom_range(255));

         pick = $urandom_range(99);
         if (painted_columns.size() > 0 && pick < 70)
            rbyte = BYTE_W'(painted_columns[$urandom_range(painted_columns.size() - 1)] >> 2);
         else if (row_len > 0 && pick < 90)
            rbyte = BYTE_W'($urandom_range(row_len - 1));
         else
            rbyte = BYTE_W'($urandom_range(255));

         if ((kind == KIND_STEREO || kind == KIND_MONO) && column < uw) begin
            painted_columns.push_back(column);
            if (painted_columns.size() > RECENT_DEPTH) void'(painted_columns.pop_front());
         end
         send_request(kind, column, lamp, ramp, row, rbyte);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset geometry: full, half and empty columns, edges of the width, unused kind, reads at row and byte edges
      send_request(KIND_STEREO, 12'd0,    15'h7FFF, 15'h7FFF, 8'd0,   8'd0);
      send_request(KIND_STEREO, 12'd1023, 15'd0,    15'd0,    8'd255, 8'd255);
      send_request(KIND_MONO,   12'd5,    15'h7FFF, 15'd0,    8'd0,   8'd0);
      send_request(KIND_MONO,   12'd6,    15'd0,    15'h7FFF, 8'd0,   8'd0);
      send_request(KIND_STEREO, 12'd1024, 15'h7FFF, 15'h7FFF, 8'd0,   8'd0);
      send_request(KIND_MONO,   12'd4095, 15'h7FFF, 15'd0,    8'd0,   8'd0);
      send_request(KIND_UNUSED, 12'd4095, 15'h7FFF, 15'h7FFF, 8'd255, 8'd255);
      send_request(KIND_STEREO, 12'd2,    15'd16384, 15'd1,   8'd0,   8'd0);
      send_request(KIND_STEREO, 12'd3,    15'd1,    15'd16384, 8'd0,  8'd0);
      send_request(KIND_READ,   12'd0,    15'd0,    15'd0,    8'd0,   8'd0);
      send_request(KIND_READ,   12'd0,    15'd0,    15'd0,    8'd255, 8'd0);
      send_request(KIND_READ,   12'd0,    15'd0,    15'd0,    8'd127, 8'd0);
      send_request(KIND_READ,   12'd0,    15'd0,    15'd0,    8'd128, 8'd0);
      send_request(KIND_READ,   12'd0,    15'd0,    15'd0,    8'd64,  8'd0);
      send_request(KIND_READ,   12'd0,    15'd0,    15'd0,    8'd192, 8'd0);
      send_request(KIND_READ,   12'd0,    15'd0,    15'd0,    8'd0,   8'd1);
      send_request(KIND_READ,   12'd0,    15'd0,    15'd0,    8'd255, 8'd1);
      send_request(KIND_READ,   12'd0,    15'd0,    15'd0,    8'd128, 8'd255);
      send_request(KIND_READ,   12'd0,    15'd0,    15'd0,    8'd255, 8'd255);
      send_request(KIND_READ,   12'd0,    15'd0,    15'd0,    8'd200, 8'd200);

      run_phase(11'd40,   9'd16,  2'd3, 2'd1,  0,  0, 180);
      run_phase(11'd2047, 9'd511, 2'd2, 2'd3, 49,  0, 150);
      run_phase(11'd17,   9'd7,   2'd1, 2'd2,  0, 49, 200);
      run_phase(11'd16,   9'd6,   2'd3, 2'd3, 17, 17, 180);
      run_phase(11'd0,    9'd0,   2'd0, 2'd0,  0,  0,  40);
      run_phase(11'd5,    9'd1,   2'd1, 2'd1, 17, 17,  40);
      run_phase(11'd1024, 9'd256, 2'd0, 2'd1,  0,  0, 150);
      run_phase(11'd300,  9'd100, 2'd2, 2'd1, 49,  0, 150);
      run_phase(11'd1023, 9'd255, 2'd3, 2'd2,  0, 49, 150);
      run_phase(11'd64,   9'd32,  2'd1, 2'd2, 17, 17, 180);

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mirror.failures == 0)
         $display("waveform_column_rasterizer_core regression: pass");
      else
         $display("waveform_column_rasterizer_core regression: fail");
      $finish;
   end

endmodule
